>>> hdl/aqs_pkg.sv
// Shared widths and constants for the aliquot sum block.
// Used by aqs_divider, aliquot_sum_perfect_test and the testbench; depends on nothing.
package aqs_pkg;

  // Width of the number whose proper divisors are summed.
  localparam int VALUE_WIDTH = 32;
  // Width of the divisor sum; the sum saturates at its all-ones value.
  localparam int SUM_WIDTH = 35;
  // Common width for comparing a value against a sum.
  localparam int WIDE_WIDTH = (VALUE_WIDTH > SUM_WIDTH) ? VALUE_WIDTH : SUM_WIDTH;
  // Accumulator adder width, one carry bit above the common width.
  localparam int ADD_WIDTH = WIDE_WIDTH + 1;
  // Bit counter width for the divider, able to hold VALUE_WIDTH itself.
  localparam int CNT_WIDTH = $clog2(VALUE_WIDTH + 1);

endpackage

>>> hdl/aliquot_sum_perfect_test.sv
// Aliquot sum by trial division over candidates 1 .. isqrt(n), with flags.
// Each candidate runs through the serial divider, and each divisor found adds
// into the accumulator; values 0 and 1 skip the search. One transaction at
// a time: in_ready is high only while the sequencer is idle.
// Reset: synchronous active-low rst_n returns the sequencer to idle and
// drops out_valid. Depends on aqs_pkg and aqs_divider.
module aliquot_sum_perfect_test (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [aqs_pkg::VALUE_WIDTH-1:0] in_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [aqs_pkg::SUM_WIDTH-1:0]   out_divisor_sum,
  output logic                            out_is_perfect,
  output logic                            out_is_prime
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_ADD_D,
    ST_ADD_Q,
    ST_FINISH
  } state_t;

  state_t                          state_r, state_nxt;
  logic [aqs_pkg::VALUE_WIDTH-1:0] n_r, n_nxt;
  logic [aqs_pkg::VALUE_WIDTH-1:0] d_r, d_nxt;
  logic [aqs_pkg::SUM_WIDTH-1:0]   acc_r, acc_nxt;
  logic                            sat_r, sat_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [aqs_pkg::SUM_WIDTH-1:0]   sum_out_r, sum_out_nxt;
  logic                            perfect_r, perfect_nxt;
  logic                            prime_r, prime_nxt;

  logic                            div_start;
  logic                            div_done;
  logic [aqs_pkg::VALUE_WIDTH-1:0] quot;
  logic [aqs_pkg::VALUE_WIDTH-1:0] rem;
  logic [aqs_pkg::VALUE_WIDTH-1:0] addend;
  logic [aqs_pkg::ADD_WIDTH-1:0]   add_sum;
  logic                            add_ovf;

  aqs_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (n_r),
    .divisor   (d_r),
    .quotient  (quot),
    .remainder (rem),
    .done      (div_done)
  );

  // Shared saturating accumulate: the candidate itself, or its partner quotient.
  always_comb begin
    addend  = (state_r == ST_ADD_Q) ? quot : d_r;
    add_sum = aqs_pkg::ADD_WIDTH'(acc_r) + aqs_pkg::ADD_WIDTH'(addend);
    add_ovf = (add_sum[aqs_pkg::ADD_WIDTH-1:aqs_pkg::SUM_WIDTH] != '0);
  end

  assign div_start = (state_r == ST_START);
  assign in_ready  = (state_r == ST_IDLE);

  // Trial-division sequencer.
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    acc_nxt       = acc_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r;
    sum_out_nxt   = sum_out_r;
    perfect_nxt   = perfect_r;
    prime_nxt     = prime_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          n_nxt   = in_value;
          d_nxt   = aqs_pkg::VALUE_WIDTH'(1);
          acc_nxt = '0;
          sat_nxt = 1'b0;
          // Zero and one have no proper divisors to search for.
          if (in_value[aqs_pkg::VALUE_WIDTH-1:1] == '0) begin
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_START;
          end
        end
      end
      ST_START: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          if (d_r > quot) begin
            state_nxt = ST_FINISH;
          end else if (rem == '0) begin
            state_nxt = ST_ADD_D;
          end else begin
            d_nxt     = d_r + 1'b1;
            state_nxt = ST_START;
          end
        end
      end
      ST_ADD_D: begin
        if (add_ovf) begin
          acc_nxt = '1;
          sat_nxt = 1'b1;
        end else begin
          acc_nxt = add_sum[aqs_pkg::SUM_WIDTH-1:0];
        end
        // Candidate one pairs with n itself, and a square root counts once.
        if (d_r != aqs_pkg::VALUE_WIDTH'(1) && quot != d_r) begin
          state_nxt = ST_ADD_Q;
        end else begin
          d_nxt     = d_r + 1'b1;
          state_nxt = ST_START;
        end
      end
      ST_ADD_Q: begin
        if (add_ovf) begin
          acc_nxt = '1;
          sat_nxt = 1'b1;
        end else begin
          acc_nxt = add_sum[aqs_pkg::SUM_WIDTH-1:0];
        end
        d_nxt     = d_r + 1'b1;
        state_nxt = ST_START;
      end
      ST_FINISH: begin
        // Load the result register once the previous result has left.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          sum_out_nxt   = acc_r;
          perfect_nxt   = (n_r != '0) && !sat_r &&
                          (aqs_pkg::WIDE_WIDTH'(n_r) == aqs_pkg::WIDE_WIDTH'(acc_r));
          prime_nxt     = (acc_r == aqs_pkg::SUM_WIDTH'(1));
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    d_r       <= d_nxt;
    acc_r     <= acc_nxt;
    sat_r     <= sat_nxt;
    sum_out_r <= sum_out_nxt;
    perfect_r <= perfect_nxt;
    prime_r   <= prime_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_divisor_sum = sum_out_r;
  assign out_is_perfect  = perfect_r;
  assign out_is_prime    = prime_r;

endmodule

>>> hdl/aqs_divider.sv
// Restoring radix-2 divider producing one quotient bit per cycle.
// Depends on aqs_pkg for the operand width and counter width.
module aqs_divider (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [aqs_pkg::VALUE_WIDTH-1:0]   dividend,
  input  logic [aqs_pkg::VALUE_WIDTH-1:0]   divisor,
  output logic [aqs_pkg::VALUE_WIDTH-1:0]   quotient,
  output logic [aqs_pkg::VALUE_WIDTH-1:0]   remainder,
  output logic                              done
);

  logic [aqs_pkg::VALUE_WIDTH-1:0] quot_r, quot_nxt;
  logic [aqs_pkg::VALUE_WIDTH-1:0] rem_r, rem_nxt;
  logic [aqs_pkg::VALUE_WIDTH-1:0] dsr_r, dsr_nxt;
  logic [aqs_pkg::CNT_WIDTH-1:0]   cnt_r, cnt_nxt;
  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [aqs_pkg::VALUE_WIDTH:0]   rem_sh;
  logic [aqs_pkg::VALUE_WIDTH+1:0] trial;

  // One shift-and-subtract step: bring down the next dividend bit.
  always_comb begin
    rem_sh = {rem_r, quot_r[aqs_pkg::VALUE_WIDTH-1]};
    trial  = {1'b0, rem_sh} - {2'b00, dsr_r};
  end

  // Step sequencing and operand loading.
  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quot_nxt = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = aqs_pkg::CNT_WIDTH'(aqs_pkg::VALUE_WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial[aqs_pkg::VALUE_WIDTH+1]) begin
        rem_nxt = rem_sh[aqs_pkg::VALUE_WIDTH-1:0];
      end else begin
        rem_nxt = trial[aqs_pkg::VALUE_WIDTH-1:0];
      end
      quot_nxt = {quot_r[aqs_pkg::VALUE_WIDTH-2:0], ~trial[aqs_pkg::VALUE_WIDTH+1]};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == aqs_pkg::CNT_WIDTH'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient  = quot_r;
  assign remainder = rem_r;
  assign done      = done_r;

endmodule

>>> verif/aqs_sum_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the aliquot sum block: watches both channels and computes the
// proper divisor sum of every accepted number. Depends on aqs_pkg.
module aqs_sum_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [aqs_pkg::VALUE_WIDTH-1:0] in_value,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [aqs_pkg::SUM_WIDTH-1:0]   out_divisor_sum,
  input  logic                            out_is_perfect,
  input  logic                            out_is_prime,
  output int                              mismatches,
  output int                              outstanding
);

  localparam logic [63:0] NUMBER_MASK = (64'd1 << aqs_pkg::VALUE_WIDTH) - 64'd1;
  localparam logic [63:0] SUM_LIMIT = (64'd1 << aqs_pkg::SUM_WIDTH) - 64'd1;

  typedef struct packed {
    logic [aqs_pkg::SUM_WIDTH-1:0] divisor_sum;
    logic                          is_perfect;
    logic                          is_prime;
  } divisor_result_t;

  divisor_result_t pending_sums[$];
  int              error_total = 0;

  // Trial division over candidates 1 .. isqrt(n). The candidate 1 adds only
  // itself, a square root divisor adds once, and every other divisor adds
  // itself and its partner. The sum clamps at its all-ones value.
  function automatic divisor_result_t aliquot_of(input logic [63:0] raw);
    logic [63:0]     n;
    logic [63:0]     total;
    logic [63:0]     cand;
    logic [63:0]     partner;
    logic [63:0]     gain;
    bit              clamped;
    divisor_result_t res;
    n = raw & NUMBER_MASK;
    total = 64'd0;
    clamped = 1'b0;
    if (n >= 64'd2) begin
      for (cand = 64'd1; cand <= n / cand; cand++) begin
        if (n % cand == 64'd0) begin
          partner = n / cand;
          if (cand == 64'd1) begin
            gain = 64'd1;
          end else if (partner == cand) begin
            gain = cand;
          end else begin
            gain = cand + partner;
          end
          if (gain > SUM_LIMIT - total) begin
            clamped = 1'b1;
            total = SUM_LIMIT;
          end else begin
            total = total + gain;
          end
        end
      end
    end
    res.divisor_sum = total[aqs_pkg::SUM_WIDTH-1:0];
    res.is_perfect = (n != 64'd0) && !clamped && (n == total);
    res.is_prime = (total == 64'd1);
    return res;
  endfunction

  // Results are matched first, so a transaction that leaves in the same cycle
  // as a new one enters is paired with an older expectation.
  always @(posedge clk) begin
    divisor_result_t want;
    divisor_result_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.divisor_sum = out_divisor_sum;
        got.is_perfect = out_is_perfect;
        got.is_prime = out_is_prime;
        if (pending_sums.size() == 0) begin
          error_total++;
          if (error_total <= 10) begin
            $display("[%0t] unexpected result: sum=%0d perfect=%0b prime=%0b",
                     $realtime, got.divisor_sum, got.is_perfect, got.is_prime);
          end
        end else begin
          want = pending_sums.pop_front();
          if (got !== want) begin
            error_total++;
            if (error_total <= 10) begin
              $display("[%0t] mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                       $realtime, want.divisor_sum, want.is_perfect, want.is_prime,
                       got.divisor_sum, got.is_perfect, got.is_prime);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_sums.push_back(aliquot_of({{(64 - aqs_pkg::VALUE_WIDTH){1'b0}}, in_value}));
      end
    end
    mismatches <= error_total;
    outstanding <= pending_sums.size();
  end

endmodule

>>> verif/tb_aliquot_sum_perfect_test.sv
`timescale 1ns / 1ps
// Top of the aliquot sum testbench: clock, reset, number stimulus and verdict.
// Depends on aqs_pkg, aliquot_sum_perfect_test and aqs_sum_checker.
module tb_aliquot_sum_perfect_test;

  localparam int VW = aqs_pkg::VALUE_WIDTH;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [VW-1:0]                 in_value = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [aqs_pkg::SUM_WIDTH-1:0] out_divisor_sum;
  logic                          out_is_perfect;
  logic                          out_is_prime;
  int                            mismatches;
  int                            outstanding;

  int burst_left = 0;
  int accept_pct = 100;
  int stall_span = 0;

  always #10 clk = ~clk;

  aliquot_sum_perfect_test u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_divisor_sum (out_divisor_sum),
    .out_is_perfect  (out_is_perfect),
    .out_is_prime    (out_is_prime)
  );

  aqs_sum_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_divisor_sum (out_divisor_sum),
    .out_is_perfect  (out_is_perfect),
    .out_is_prime    (out_is_prime),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  // The receiver picks a new acceptance rate whenever its stall span runs out,
  // including a rate at which it never stalls.
  always @(posedge clk) begin
    if (stall_span == 0) begin
      case ($urandom_range(0, 3))
        0: accept_pct = 100;
        1: accept_pct = 70;
        2: accept_pct = 30;
        default: accept_pct = 5;
      endcase
      stall_span = $urandom_range(20, 200);
    end else begin
      stall_span--;
    end
    out_ready <= ($urandom_range(1, 100) <= accept_pct);
  end

  // Sends one number; valid drops at the end of each burst, before the next starts.
  task automatic send_number(input logic [VW-1:0] num);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= num;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
    end
  endtask

  // Random numbers stay mostly small, since the block's latency grows with
  // the square root of the number.
  function automatic logic [VW-1:0] random_number();
    int unsigned root;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      return VW'($urandom_range(0, 4095));
    end else if (pick < 65) begin
      return VW'($urandom_range(0, 65535));
    end else if (pick < 75) begin
      // Squares exercise the single count of the root divisor.
      root = $urandom_range(2, 600);
      return VW'(root * root);
    end else if (pick < 85) begin
      return VW'($urandom_range(1, 15) << $urandom_range(0, 16));
    end else if (pick < 95) begin
      // Perfect numbers and their neighbors.
      case ($urandom_range(0, 3))
        0: root = 6;
        1: root = 28;
        2: root = 496;
        default: root = 8128;
      endcase
      return VW'(root + $urandom_range(0, 2) - 1);
    end else begin
      return VW'($urandom_range(0, (1 << 22) - 1));
    end
  endfunction

  initial begin
    logic [VW-1:0] directed[$];
    directed = '{0, 1, 2, 3, 4, 9, 25, 36, 12, 97, 6, 28, 496, 8128, 33550336,
                 220, 284, 945, 120, 1024, 65536, 65521, {VW{1'b1}}};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) begin
      send_number(directed[i]);
    end
    repeat (100) begin
      send_number(random_number());
    end
    if (burst_left != 0) begin
      in_valid <= 1'b0;
    end
    // Let the outstanding count catch up before draining.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #800000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
